FILE: rtl/rsfp_pkg.sv
// shared types and constants for the range sensor frame parser
package rsfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DIST_W = 16;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned CFG_W  = 16;

    localparam logic [BYTE_W-1:0] HEADER_VALUE = 8'hFF;
    localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

    localparam logic [DIST_W-1:0] LOWER_LIMIT_RST  = 16'd30;
    localparam logic [TICK_W-1:0] MIN_INTERVAL_RST = 16'd100;

    // configuration register indexes
    localparam logic CFG_LOWER_LIMIT  = 1'b0;
    localparam logic CFG_MIN_INTERVAL = 1'b1;

    // input word kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // result status codes
    localparam logic STAT_GOOD = 1'b0;
    localparam logic STAT_CSUM = 1'b1;

    // frame position codes
    localparam logic [1:0] POS_HUNT  = 2'd0;
    localparam logic [1:0] POS_HIGH  = 2'd1;
    localparam logic [1:0] POS_LOW   = 2'd2;
    localparam logic [1:0] POS_CSUM  = 2'd3;

    typedef struct packed {
        logic              status;
        logic [DIST_W-1:0] distance_mm;
    } t_result;

endpackage

FILE: rtl/rsfp_frame_eval.sv
// frame state tracking, tick counting and checksum evaluation
module rsfp_frame_eval (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_action,
    input  logic [rsfp_pkg::BYTE_W-1:0]  i_byte,
    input  logic [rsfp_pkg::DIST_W-1:0]  i_lower_limit,
    input  logic [rsfp_pkg::TICK_W-1:0]  i_min_interval,
    output logic                         o_res_valid,
    output rsfp_pkg::t_result            o_res
);

    logic [1:0]                  r_pos,   n_pos;
    logic [rsfp_pkg::BYTE_W-1:0] r_high,  n_high;
    logic [rsfp_pkg::BYTE_W-1:0] r_low,   n_low;
    logic [rsfp_pkg::TICK_W-1:0] r_ticks, n_ticks;
    logic [rsfp_pkg::DIST_W-1:0] r_held,  n_held;

    logic [rsfp_pkg::BYTE_W-1:0] sum;
    logic [rsfp_pkg::DIST_W-1:0] raw_dist;
    logic [rsfp_pkg::DIST_W-1:0] clamp_dist;
    logic                        good;
    logic                        too_early;

    assign sum        = rsfp_pkg::HEADER_VALUE + r_high + r_low;
    assign good       = (sum == i_byte);
    assign raw_dist   = {r_high, r_low};
    assign clamp_dist = (raw_dist < i_lower_limit) ? i_lower_limit : raw_dist;
    assign too_early  = (r_ticks < i_min_interval);

    always_comb begin
        n_pos       = r_pos;
        n_high      = r_high;
        n_low       = r_low;
        n_ticks     = r_ticks;
        n_held      = r_held;
        o_res_valid = 1'b0;
        o_res       = '{status: rsfp_pkg::STAT_GOOD, distance_mm: r_held};
        if (i_en) begin
            if (i_action == rsfp_pkg::ACT_TICK) begin
                if (r_ticks != rsfp_pkg::TICK_MAX) begin
                    n_ticks = r_ticks + 1'b1;
                end
            end else begin
                unique case (r_pos)
                    rsfp_pkg::POS_HUNT: begin
                        if (i_byte == rsfp_pkg::HEADER_VALUE) begin
                            n_pos = rsfp_pkg::POS_HIGH;
                        end
                    end
                    rsfp_pkg::POS_HIGH: begin
                        n_high = i_byte;
                        n_pos  = rsfp_pkg::POS_LOW;
                    end
                    rsfp_pkg::POS_LOW: begin
                        n_low = i_byte;
                        n_pos = rsfp_pkg::POS_CSUM;
                    end
                    default: begin
                        n_pos = rsfp_pkg::POS_HUNT;
                        // frames arriving before the interval has run are dropped
                        if (!too_early) begin
                            n_ticks     = '0;
                            o_res_valid = 1'b1;
                            if (good) begin
                                n_held = clamp_dist;
                                o_res  = '{status: rsfp_pkg::STAT_GOOD,
                                           distance_mm: clamp_dist};
                            end else begin
                                o_res  = '{status: rsfp_pkg::STAT_CSUM,
                                           distance_mm: r_held};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= rsfp_pkg::POS_HUNT;
            r_high  <= '0;
            r_low   <= '0;
            r_ticks <= '0;
            r_held  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_high  <= n_high;
            r_low   <= n_low;
            r_ticks <= n_ticks;
            r_held  <= n_held;
        end
    end

endmodule

FILE: rtl/rsfp_out_buf.sv
// result register with a skid stage toward the output stream
module rsfp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rsfp_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output rsfp_pkg::t_result o_data
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    rsfp_pkg::t_result r_main,       n_main;
    rsfp_pkg::t_result r_skid,       n_skid;
    logic              pop;

    assign pop     = r_main_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (!r_main_valid) begin
            n_main       = i_data;
            n_main_valid = i_push;
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

FILE: rtl/range_sensor_frame_parser.sv
// range sensor frame parser: input register, frame evaluation and output buffer
//
// input stream carries one word per received uart byte or per millisecond tick:
// tuser = 1 marks a tick, tuser = 0 a byte held in tdata. frames are header 0xff,
// distance high, distance low, checksum. a frame that completes after at least
// min_interval ticks since the last evaluated frame gives one output word:
// tuser = 0 good frame, 1 checksum error; tdata = held distance in mm.
// registers: index 0 lower limit (reset 30), index 1 min interval (reset 100),
// written through i_cfg_we / i_cfg_index / i_cfg_data; the user writes them only
// while idle, the block itself does not enforce this. each word is registered in
// the input stage, its result in the output buffer; one word per cycle unless full.
// a two-deep result buffer (register plus skid) absorbs a stalled receiver;
// input tready drops only while that buffer is full and the input stage holds
// a word. reset clears frame position, tick count, held distance and buffers,
// and returns the registers to their reset values.
module range_sensor_frame_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rsfp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                   s_axis_tuser,   // [0] action
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [15:0] distance_mm
    output logic [0:0]                   m_axis_tuser    // [0] status
);

    logic [rsfp_pkg::DIST_W-1:0] r_lower_limit;
    logic [rsfp_pkg::TICK_W-1:0] r_min_interval;

    logic                        r_in_valid;
    logic                        r_in_action;
    logic [rsfp_pkg::BYTE_W-1:0] r_in_byte;

    logic              space;
    logic              advance;
    logic              res_valid;
    rsfp_pkg::t_result res;
    rsfp_pkg::t_result out_res;

    assign advance       = r_in_valid & space;
    assign s_axis_tready = ~r_in_valid | space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit  <= rsfp_pkg::LOWER_LIMIT_RST;
            r_min_interval <= rsfp_pkg::MIN_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsfp_pkg::CFG_LOWER_LIMIT:  r_lower_limit  <= i_cfg_data;
                rsfp_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_action <= s_axis_tuser[0];
            r_in_byte   <= s_axis_tdata;
        end
    end

    rsfp_frame_eval u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_action       (r_in_action),
        .i_byte         (r_in_byte),
        .i_lower_limit  (r_lower_limit),
        .i_min_interval (r_min_interval),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    rsfp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata    = out_res.distance_mm;
    assign m_axis_tuser[0] = out_res.status;

endmodule
